>>> rtl/cvi_pkg.sv
// package for the coordinate to voxel index unit: types, register codes, widths
`default_nettype none
package cvi_pkg;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned PITCH_W = 31;
  localparam int unsigned COUNTS_W = 33;
  localparam int unsigned IDX_W = 11;
  localparam int unsigned LIN_W = 30;
  localparam int unsigned QBITS = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAX_DIM_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COUNTS = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [QBITS-1:0] quo;
    logic zero;
    logic sat;
  } cvi_cell_t;
endpackage
`default_nettype wire

>>> rtl/cvi_div_cell.sv
// one restoring division cell: resolves one quotient bit and passes on
`default_nettype none
module cvi_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [cvi_pkg::PITCH_W-1:0] pitch,
  input  wire cvi_pkg::cvi_cell_t         d_in,
  output cvi_pkg::cvi_cell_t              d_out
);
  localparam int unsigned CW = cvi_pkg::PITCH_W + cvi_pkg::QBITS;

  logic [CW-1:0] shifted;
  logic [CW-1:0] rem_ext;
  logic [CW-1:0] diff;
  cvi_pkg::cvi_cell_t cell_nxt;

  always_comb begin
    shifted = {{(CW-cvi_pkg::PITCH_W){1'b0}}, pitch} << BIT;
    rem_ext = {{(CW-cvi_pkg::COORD_W){1'b0}}, d_in.rem};
    diff = rem_ext - shifted;
    cell_nxt = d_in;
    if (!d_in.zero && !d_in.sat && rem_ext >= shifted) begin
      cell_nxt.rem = diff[cvi_pkg::COORD_W-1:0];
      cell_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= cell_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/cvi_axis.sv
// one axis: offset and range check, chain of division cells, clamp to count
`default_nettype none
module cvi_axis (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [cvi_pkg::COORD_W-1:0] point,
  input  wire logic [cvi_pkg::COORD_W-1:0] corner,
  input  wire logic [cvi_pkg::PITCH_W-1:0] pitch,
  input  wire logic [cvi_pkg::IDX_W-1:0]   count,
  output logic [cvi_pkg::IDX_W-1:0]        idx_r,
  output logic                             ok_r
);
  localparam int unsigned CW = cvi_pkg::PITCH_W + cvi_pkg::QBITS;
  localparam int unsigned QB = cvi_pkg::QBITS;

  logic [cvi_pkg::COORD_W:0] diff;
  logic [CW-1:0] rem_ext;
  logic [CW-1:0] limit;
  cvi_pkg::cvi_cell_t front_nxt;
  cvi_pkg::cvi_cell_t chain [0:QB];
  logic [cvi_pkg::IDX_W-1:0] idx_nxt;
  logic ok_nxt;

  always_comb begin
    diff = {point[cvi_pkg::COORD_W-1], point} - {corner[cvi_pkg::COORD_W-1], corner};
    rem_ext = {{(CW-cvi_pkg::COORD_W){1'b0}}, diff[cvi_pkg::COORD_W-1:0]};
    limit = {pitch, {QB{1'b0}}};
    front_nxt.rem = diff[cvi_pkg::COORD_W-1:0];
    front_nxt.quo = '0;
    front_nxt.zero = diff[cvi_pkg::COORD_W] || (pitch == '0);
    front_nxt.sat = !front_nxt.zero && (rem_ext >= limit);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= front_nxt;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_cell
    cvi_div_cell #(
      .BIT(QB - 1 - g)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .pitch (pitch),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  always_comb begin
    priority if (chain[QB].zero) begin
      idx_nxt = '0;
      ok_nxt = 1'b0;
    end else if (chain[QB].sat || chain[QB].quo >= count) begin
      idx_nxt = count;
      ok_nxt = 1'b0;
    end else begin
      idx_nxt = chain[QB].quo;
      ok_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= idx_nxt;
      ok_r <= ok_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/coordinate_to_voxel_index_unit.sv
// top level: config registers, three axis chains, linear index and output stage
//
//  channel | direction | handshake        | payload
//  in_     | input     | valid / stall    | point_x, point_y, point_z
//  out_    | output    | valid / stall    | hit, linear_index, col/row/slice_index
//  cfg_    | input     | valid / ready    | index, data
//
//  one item per cycle unless out_stall holds a waiting result; stages: 1 offset,
//  11 division cells, 1 clamp, 1 multiply, 1 add stage into the output register
//  the 11-cell restoring division chain per axis sets the latency
//  synchronous active-low reset clears valids and config to defaults
//  out_stall freezes the whole pipeline and raises in_stall while a result waits
`default_nettype none
module coordinate_to_voxel_index_unit #(
  parameter int unsigned MAX_DIM = cvi_pkg::MAX_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [cvi_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [cvi_pkg::COORD_W-1:0] in_point_y,
  input  wire logic signed [cvi_pkg::COORD_W-1:0] in_point_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_hit,
  output logic [cvi_pkg::LIN_W-1:0]           out_linear_index,
  output logic [cvi_pkg::IDX_W-1:0]           out_col_index,
  output logic [cvi_pkg::IDX_W-1:0]           out_row_index,
  output logic [cvi_pkg::IDX_W-1:0]           out_slice_index,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cvi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cvi_pkg::COUNTS_W-1:0]   cfg_data
);
  localparam int unsigned LAT = cvi_pkg::QBITS + 4;
  localparam int unsigned IW = cvi_pkg::IDX_W;
  localparam logic [IW-1:0] MAX_N = IW'(MAX_DIM);

  logic [cvi_pkg::COORD_W-1:0] corner_x_r, corner_y_r, corner_z_r;
  logic [cvi_pkg::PITCH_W-1:0] pitch_x_r, pitch_y_r, pitch_z_r;
  logic [cvi_pkg::COUNTS_W-1:0] counts_r;
  logic [IW-1:0] nx, ny, nz, raw_x, raw_y, raw_z;
  logic [2*IW-1:0] nxny_r;
  logic [LAT-2:0] vld_r;
  logic adv;
  logic [IW-1:0] ix, iy, iz;
  logic okx, oky, okz;
  logic [2*IW-1:0] part_a_r;
  logic [3*IW-1:0] part_b_r;
  logic [IW-1:0] ix_r, iy_r, iz_r;
  logic hit_r;
  logic [3*IW-1:0] lin_sum;

  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_x_r <= '0;
      corner_y_r <= '0;
      corner_z_r <= '0;
      pitch_x_r <= 31'd65536;
      pitch_y_r <= 31'd65536;
      pitch_z_r <= 31'd65536;
      counts_r <= 33'd268566592;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cvi_pkg::REG_CORNER_X: corner_x_r <= cfg_data[cvi_pkg::COORD_W-1:0];
        cvi_pkg::REG_CORNER_Y: corner_y_r <= cfg_data[cvi_pkg::COORD_W-1:0];
        cvi_pkg::REG_CORNER_Z: corner_z_r <= cfg_data[cvi_pkg::COORD_W-1:0];
        cvi_pkg::REG_PITCH_X: pitch_x_r <= cfg_data[cvi_pkg::PITCH_W-1:0];
        cvi_pkg::REG_PITCH_Y: pitch_y_r <= cfg_data[cvi_pkg::PITCH_W-1:0];
        cvi_pkg::REG_PITCH_Z: pitch_z_r <= cfg_data[cvi_pkg::PITCH_W-1:0];
        cvi_pkg::REG_GRID_COUNTS: counts_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_x = counts_r[IW-1:0];
    raw_y = counts_r[2*IW-1:IW];
    raw_z = counts_r[3*IW-1:2*IW];
    nx = (raw_x > MAX_N) ? MAX_N : raw_x;
    ny = (raw_y > MAX_N) ? MAX_N : raw_y;
    nz = (raw_z > MAX_N) ? MAX_N : raw_z;
  end

  always_ff @(posedge clk) begin
    nxny_r <= nx * ny;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-3:0], in_valid};
      out_valid <= vld_r[LAT-2];
    end
  end

  cvi_axis u_axis_x (
    .clk(clk), .en(adv), .point(in_point_x), .corner(corner_x_r),
    .pitch(pitch_x_r), .count(nx), .idx_r(ix), .ok_r(okx)
  );
  cvi_axis u_axis_y (
    .clk(clk), .en(adv), .point(in_point_y), .corner(corner_y_r),
    .pitch(pitch_y_r), .count(ny), .idx_r(iy), .ok_r(oky)
  );
  cvi_axis u_axis_z (
    .clk(clk), .en(adv), .point(in_point_z), .corner(corner_z_r),
    .pitch(pitch_z_r), .count(nz), .idx_r(iz), .ok_r(okz)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      part_a_r <= {{IW{1'b0}}, ix} + iy * nx;
      part_b_r <= iz * nxny_r;
      ix_r <= ix;
      iy_r <= iy;
      iz_r <= iz;
      hit_r <= okx && oky && okz;
    end
  end

  assign lin_sum = {{IW{1'b0}}, part_a_r} + part_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= hit_r;
      out_linear_index <= hit_r ? lin_sum[cvi_pkg::LIN_W-1:0] : '0;
      out_col_index <= ix_r;
      out_row_index <= iy_r;
      out_slice_index <= iz_r;
    end
  end
endmodule
`default_nettype wire
